// ===== sv/point_projection_depth_visibility_defines.svh =====
// ----------------------------------------------------------------------------
// point projection depth visibility: assertion macros
// shared assertion forms for the projection block
// ----------------------------------------------------------------------------
`ifndef POINT_PROJECTION_DEPTH_VISIBILITY_DEFINES_SVH
`define POINT_PROJECTION_DEPTH_VISIBILITY_DEFINES_SVH

// same-cycle implication
`define PPDV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PPDV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/ppdv_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdv_pkg
// types and codes of the point projection depth visibility block
// ----------------------------------------------------------------------------
package ppdv_pkg;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   localparam logic [1:0] ST_VISIBLE  = 2'd0;
   localparam logic [1:0] ST_OUTSIDE  = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;
   localparam logic [1:0] ST_MISMATCH = 2'd3;

   localparam logic [1:0] CSR_FOCAL  = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_THRESH = 2'd3;

   // item state carried down the pipeline
   typedef struct packed {
      logic        kind;
      logic [19:0] lpix;
      logic [31:0] ldepth;
      logic        lvalid;
      logic [31:0] z;
      logic        outside;
   } item_type;

endpackage

// ===== sv/point_projection_depth_visibility.sv =====
// ----------------------------------------------------------------------------
// point_projection_depth_visibility
// pinhole projection of model points against a stored scene depth image
// ----------------------------------------------------------------------------
// The req channel carries two kinds of transfer, chosen by req_tuser: a load
// writes one scene pixel (depth and valid mark) into the on-chip depth image,
// a test projects one point and yields one rsp transfer with status and pixel.
// Loads yield no rsp transfer. Items are handled strictly in order, so a test
// sees every load accepted before it.
// Throughput is one item per cycle while the receiver does not stall. The
// restoring divider yields Q quotient bits, one per pipeline stage, with Q =
// bits of the image dimension (11 at the default size).
// The pipeline advances as a whole whenever the rsp register is empty or
// taken; when the receiver stalls, req_tready drops and all stages hold.
// Reset clears pipeline valid bits and loads the default camera settings;
// the depth image is not cleared, a pixel must be loaded before it is tested.
// The user writes settings through the csr port while idle; the block does not check.
// ----------------------------------------------------------------------------
`include "point_projection_depth_visibility_defines.svh"

module point_projection_depth_visibility
   import ppdv_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // load_pixel[19:0], load_depth[51:20], load_valid[52], point_x[84:53],
   // point_y[116:85], point_z[148:117], zero fill [151:149]
   input  logic [151:0] req_tdata,
   // kind[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], hit_pixel[21:2], zero fill [23:22]
   output logic [23:0]  rsp_tdata
);

   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int HB    = $clog2(MAX_HEIGHT + 1);
   localparam int DW0   = (WB > HB) ? WB : HB;
   localparam int DW    = (DW0 > 11) ? DW0 : 11;
   localparam int QB    = DW;
   localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIXB  = $clog2(STORE);

   // settings
   logic [31:0] focal_ff;
   logic [10:0] width_ff;
   logic [10:0] height_ff;
   logic [23:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= 32'd34406400;
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         thresh_ff <= 24'd655;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FOCAL:  focal_ff  <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            CSR_HEIGHT: height_ff <= csr_wdata[10:0];
            CSR_THRESH: thresh_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0] dim [2];
   logic [DW+14:0] cmag [2];
   logic           cneg [2];

   always_comb begin
      dim[0] = (DW'(width_ff) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(width_ff);
      dim[1] = (DW'(height_ff) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(height_ff);
      for (int a = 0; a < 2; a++) begin
         cneg[a] = (dim[a] == '0);
         cmag[a] = cneg[a] ? (DW+15)'(32768) : {dim[a] - DW'(1), 15'd0};
      end
   end

   logic adv;
   logic rsp_tvalid_ff;
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: products
   item_type    itm1_in, itm1_ff;
   logic        vld1_ff;
   logic [63:0] ma1_ff [2], ma1_in [2];
   logic [63:0] mb1_ff [2], mb1_in [2];
   logic        na1_ff [2], na1_in [2];
   logic        nb1_ff [2];
   logic signed [31:0] pin [2];
   logic [31:0] pmag [2];

   always_comb begin
      pin[0] = req_tdata[84:53];
      pin[1] = req_tdata[116:85];
      itm1_in.kind    = req_tuser[0];
      itm1_in.lpix    = req_tdata[19:0];
      itm1_in.ldepth  = req_tdata[51:20];
      itm1_in.lvalid  = req_tdata[52];
      itm1_in.z       = req_tdata[148:117];
      itm1_in.outside = ($signed(req_tdata[148:117]) <= 0);
      for (int a = 0; a < 2; a++) begin
         na1_in[a] = pin[a][31];
         pmag[a]   = pin[a][31] ? 32'(-pin[a]) : 32'(pin[a]);
         ma1_in[a] = 64'(focal_ff) * 64'(pmag[a]);
         mb1_in[a] = 64'(cmag[a] * 64'(req_tdata[147:117]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else if (adv) vld1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm1_ff <= itm1_in;
         for (int a = 0; a < 2; a++) begin
            ma1_ff[a] <= ma1_in[a];
            mb1_ff[a] <= mb1_in[a];
            na1_ff[a] <= na1_in[a];
            nb1_ff[a] <= cneg[a];
         end
      end
   end

   // stage 2: signed sum as magnitude and sign
   item_type    itm2_ff;
   logic        vld2_ff;
   logic [63:0] m2_ff [2], m2_in [2];
   logic        neg2_ff [2], neg2_in [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         if (na1_ff[a] == nb1_ff[a]) begin
            neg2_in[a] = na1_ff[a];
            m2_in[a]   = ma1_ff[a] + mb1_ff[a];
         end else if (ma1_ff[a] >= mb1_ff[a]) begin
            neg2_in[a] = na1_ff[a];
            m2_in[a]   = ma1_ff[a] - mb1_ff[a];
         end else begin
            neg2_in[a] = nb1_ff[a];
            m2_in[a]   = mb1_ff[a] - ma1_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld2_ff <= 1'b0;
      else if (adv) vld2_ff <= vld1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm2_ff <= itm1_ff;
         m2_ff   <= m2_in;
         neg2_ff <= neg2_in;
      end
   end

   // stage 3 and divider: rem/quo index s holds state after s quotient bits
   item_type      itm_ff [QB+1];
   item_type      itm3_in;
   logic [QB:0]   vldd_ff;
   logic [63:0]   rem_ff [QB+1][2];
   logic [63:0]   rem3_in [2];
   logic [QB-1:0] quo_ff [QB+1][2];
   logic [63:0]   dlim [2];

   always_comb begin
      itm3_in = itm2_ff;
      for (int a = 0; a < 2; a++) begin
         dlim[a] = 64'(itm2_ff.z[30:0]) << (16 + QB);
         if (neg2_ff[a]) begin
            // negative values in (-1, 0) truncate to column or row zero
            if (m2_ff[a] >= (64'(itm2_ff.z[30:0]) << 16)) itm3_in.outside = 1'b1;
            rem3_in[a] = '0;
         end else begin
            if (m2_ff[a] >= dlim[a]) itm3_in.outside = 1'b1;
            rem3_in[a] = m2_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vldd_ff <= '0;
      else if (adv) vldd_ff <= {vldd_ff[QB-1:0], vld2_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm_ff[0] <= itm3_in;
         for (int a = 0; a < 2; a++) begin
            rem_ff[0][a] <= rem3_in[a];
            quo_ff[0][a] <= '0;
         end
      end
   end

   for (genvar s = 0; s < QB; s++) begin : g_div
      logic [63:0]   dsh [2];
      logic [63:0]   rem_in [2];
      logic [QB-1:0] quo_in [2];
      always_comb begin
         for (int a = 0; a < 2; a++) begin
            dsh[a]    = 64'(itm_ff[s].z[30:0]) << (16 + QB - 1 - s);
            rem_in[a] = rem_ff[s][a];
            quo_in[a] = quo_ff[s][a];
            if (rem_ff[s][a] >= dsh[a]) begin
               rem_in[a]              = rem_ff[s][a] - dsh[a];
               quo_in[a][QB - 1 - s] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            itm_ff[s+1] <= itm_ff[s];
            for (int a = 0; a < 2; a++) begin
               rem_ff[s+1][a] <= rem_in[a];
               quo_ff[s+1][a] <= quo_in[a];
            end
         end
      end
   end

   // pixel index stage
   item_type        itmp_ff, itmp_in;
   logic            vldp_ff;
   logic [PIXB-1:0] pixp_ff;
   logic [2*DW-1:0] prod;

   always_comb begin
      itmp_in = itm_ff[QB];
      if (quo_ff[QB][0] >= QB'(dim[0]) || quo_ff[QB][1] >= QB'(dim[1]))
         itmp_in.outside = 1'b1;
      prod = DW'(quo_ff[QB][1]) * dim[0] + (2*DW)'(quo_ff[QB][0]);
   end

   always_ff @(posedge clock) begin
      if (reset) vldp_ff <= 1'b0;
      else if (adv) vldp_ff <= vldd_ff[QB];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itmp_ff <= itmp_in;
         pixp_ff <= PIXB'(prod);
      end
   end

   // depth image access: loads write, tests read, both in item order
   logic [32:0]     depth_mem [STORE];
   logic [32:0]     rd_ff;
   item_type        itmm_ff;
   logic            vldm_ff;
   logic [PIXB-1:0] pixm_ff;
   logic            mem_we;

   assign mem_we = adv && vldp_ff && (itmp_ff.kind == KIND_LOAD)
                   && (32'(itmp_ff.lpix) < 32'(STORE));

   always_ff @(posedge clock) begin
      if (mem_we) depth_mem[PIXB'(itmp_ff.lpix)] <= {itmp_ff.lvalid, itmp_ff.ldepth};
      if (adv) rd_ff <= depth_mem[pixp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) vldm_ff <= 1'b0;
      else if (adv) vldm_ff <= vldp_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itmm_ff <= itmp_ff;
         pixm_ff <= pixp_ff;
      end
   end

   // compare and result register
   logic [1:0]         status_in, status_ff;
   logic [19:0]        hit_in, hit_ff;
   logic signed [32:0] diff;
   logic [32:0]        adiff;

   always_comb begin
      diff  = 33'(signed'(itmm_ff.z)) - 33'(signed'(rd_ff[31:0]));
      adiff = diff[32] ? 33'(-diff) : 33'(diff);
      hit_in = 20'(pixm_ff);
      if (itmm_ff.outside) begin
         status_in = ST_OUTSIDE;
         hit_in    = '0;
      end else if (!rd_ff[32]) begin
         status_in = ST_INVALID;
      end else if (adiff < 33'(thresh_ff)) begin
         status_in = ST_VISIBLE;
      end else begin
         status_in = ST_MISMATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (adv) rsp_tvalid_ff <= vldm_ff && (itmm_ff.kind == KIND_TEST);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, hit_ff, status_ff};

   `PPDV_ASSERT_NOW(a_outside_zero, clock, reset,
      rsp_tvalid_ff && status_ff == ST_OUTSIDE, hit_ff == 20'd0)
   `PPDV_ASSERT_NOW(a_write_on_advance, clock, reset, mem_we, adv && vldp_ff)
   `PPDV_ASSERT_NEXT(a_test_gives_result, clock, reset,
      adv && vldm_ff && itmm_ff.kind == KIND_TEST, rsp_tvalid_ff)

endmodule

// ===== tb/sv/ppdv_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppdv_checker
// watches the csr port and both streams of the projection block, keeps its
// own copy of the camera settings and the scene depth image, works out the
// status and pixel of every test transfer and compares them with the rsp side
// ----------------------------------------------------------------------------
module ppdv_checker
   import ppdv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [151:0] req_tdata,
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [23:0]  rsp_tdata,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic [19:0] pixel;
   } verdict_type;

   localparam longint unsigned IMG_MAX_W = 1024;
   localparam longint unsigned IMG_MAX_H = 1024;

   logic [31:0] cfg_focal;
   logic [10:0] cfg_width;
   logic [10:0] cfg_height;
   logic [23:0] cfg_thresh;

   // depth in [31:0], valid mark in [32]
   logic [32:0] scene_img [int];
   verdict_type verdict_q [$];

   task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
      $display("%0t: mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // trunc((F*p + C*Z) / (Z*65536)) along one axis, true when it lands in [0, dim)
   function automatic bit axis_in_view(input longint unsigned f, input longint p,
                                       input longint unsigned dim, input longint unsigned z,
                                       output longint unsigned coord);
      bit na, nb, neg;
      longint c;
      longint unsigned ma, mb, m, q;
      na = p < 0;
      ma = f * (na ? longint'(-p) : p);
      c  = longint'(dim) * 32768 - 32768;
      nb = c < 0;
      mb = (nb ? longint'(-c) : c) * z;
      if (na == nb) begin
         neg = na;
         m   = ma + mb;
      end else if (ma >= mb) begin
         neg = na;
         m   = ma - mb;
      end else begin
         neg = nb;
         m   = mb - ma;
      end
      q = m / (z << 16);
      coord = 0;
      if (neg && q > 0) return 0;
      if (neg) q = 0;
      if (q >= dim) return 0;
      coord = q;
      return 1;
   endfunction

   function automatic bit project_point(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z, output logic [19:0] pixel);
      longint unsigned w, h, u, v;
      longint zs;
      w  = cfg_width  > IMG_MAX_W ? IMG_MAX_W : cfg_width;
      h  = cfg_height > IMG_MAX_H ? IMG_MAX_H : cfg_height;
      zs = longint'($signed(z));
      pixel = '0;
      if (zs <= 0) return 0;
      if (!axis_in_view(cfg_focal, longint'($signed(x)), w, zs, u)) return 0;
      if (!axis_in_view(cfg_focal, longint'($signed(y)), h, zs, v)) return 0;
      pixel = 20'(v * w + u);
      return 1;
   endfunction

   function automatic verdict_type judge_point(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z);
      verdict_type r;
      logic [32:0] e;
      longint diff;
      if (!project_point(x, y, z, r.pixel)) begin
         r.status = ST_OUTSIDE;
         r.pixel  = '0;
         return r;
      end
      e = scene_img.exists(r.pixel) ? scene_img[r.pixel] : 33'd0;
      if (!e[32]) begin
         r.status = ST_INVALID;
      end else begin
         diff = longint'($signed(z)) - longint'($signed(e[31:0]));
         if (diff < 0) diff = -diff;
         r.status = (diff < longint'(cfg_thresh)) ? ST_VISIBLE : ST_MISMATCH;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      verdict_type want, got;
      if (reset) begin
         cfg_focal  = 32'd34406400;
         cfg_width  = 11'd640;
         cfg_height = 11'd480;
         cfg_thresh = 24'd655;
         verdict_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FOCAL:  cfg_focal  = csr_wdata;
               CSR_WIDTH:  cfg_width  = csr_wdata[10:0];
               CSR_HEIGHT: cfg_height = csr_wdata[10:0];
               CSR_THRESH: cfg_thresh = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.pixel  = rsp_tdata[21:2];
            if (verdict_q.size() == 0) begin
               report("unexpected transfer", rsp_tdata, 24'd0);
            end else begin
               want = verdict_q.pop_front();
               if (got.status !== want.status) report("status", got.status, want.status);
               if (got.pixel !== want.pixel) report("hit_pixel", got.pixel, want.pixel);
               if (rsp_tdata[23:22] !== 2'b00) report("fill bits", rsp_tdata[23:22], 24'd0);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == KIND_LOAD)
               scene_img[int'(req_tdata[19:0])] = {req_tdata[52], req_tdata[51:20]};
            else
               verdict_q.insert(verdict_q.size(),
                                judge_point(req_tdata[84:53], req_tdata[116:85],
                                            req_tdata[148:117]));
         end
      end
      pending = verdict_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the point projection depth visibility block: scene loads and
// point tests over several camera settings, with bursty sending and a
// stalling receiver; checking is done by ppdv_checker
// ----------------------------------------------------------------------------
module tb;
   import ppdv_pkg::*;

   localparam int ITEMS_PER_SETTING = 275;
   localparam int DRAIN_CYCLES      = 40;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [151:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;
   int           fail_count;
   int           pending;

   bit loaded [int];
   int burst_left;
   int stall_cycle;

   point_projection_depth_visibility i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   ppdv_checker i_chk (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver stall pattern: the mode is chosen by bits [9:8] of stall_cycle
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_tready <= ($urandom_range(0, 9) != 0);
         default: rsp_tready <= (stall_cycle[4:2] != 3'd0);
      endcase
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // one transfer on the req side, called right after a falling edge
   task automatic send(input logic kind, input logic [151:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic load_pixel(input logic [19:0] pix, input logic [31:0] depth, input logic ok);
      loaded[int'(pix)] = 1'b1;
      send(KIND_LOAD, {99'd0, ok, depth, pix});
   endtask

   // a depth near z, often exactly at the edge of the tolerance
   function automatic logic [31:0] depth_near(input logic [31:0] z);
      longint d, t;
      t = i_chk.cfg_thresh;
      case ($urandom_range(0, 6))
         0: d = $signed(z);
         1: d = longint'($signed(z)) + t;
         2: d = longint'($signed(z)) - t;
         3: d = longint'($signed(z)) + t - 1;
         4: d = longint'($signed(z)) - t + 1;
         5: d = longint'($signed(z)) + $signed(32'($urandom_range(0, 2000))) - 1000;
         default: return $urandom;
      endcase
      if (d > 64'sh7FFFFFFF) d = 64'sh7FFFFFFF;
      if (d < -64'sh80000000) d = -64'sh80000000;
      return d[31:0];
   endfunction

   // a point test; the hit pixel is loaded first when it never was
   task automatic test_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      logic [19:0] pix;
      if (i_chk.project_point(x, y, z, pix) && !loaded.exists(int'(pix)))
         load_pixel(pix, depth_near(z), $urandom_range(0, 4) != 0);
      send(KIND_TEST, {3'd0, z, y, x, 1'b0, 32'd0, 20'd0});
   endtask

   function automatic logic [31:0] aim(input longint unsigned target, input longint unsigned dim,
                                       input longint z);
      longint f, num, r;
      f = i_chk.cfg_focal;
      if (f == 0 || dim == 0) return $urandom;
      num = longint'(target) * 65536 + longint'($urandom_range(0, 65535))
            - (longint'(dim) * 32768 - 32768);
      r = num * z / f;
      if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
      if (r < -64'sh80000000) r = -64'sh80000000;
      return r[31:0];
   endfunction

   task automatic random_item();
      int sel;
      longint unsigned w, h;
      longint z;
      logic [31:0] zv;
      sel = $urandom_range(0, 99);
      w = i_chk.cfg_width  > 1024 ? 1024 : i_chk.cfg_width;
      h = i_chk.cfg_height > 1024 ? 1024 : i_chk.cfg_height;
      if (sel < 12) begin
         load_pixel(20'($urandom), $urandom, $urandom_range(0, 1));
      end else if (sel < 25) begin
         test_point($urandom, $urandom, $urandom);
      end else begin
         z  = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32'h7FFFFFFF)
                                        : $urandom_range(256, 32'h00400000);
         zv = z[31:0];
         test_point(aim($urandom_range(0, w == 0 ? 0 : w - 1), w, z),
                    aim($urandom_range(0, h == 0 ? 0 : h - 1), h, z), zv);
      end
   endtask

   task automatic apply_setting(input logic [31:0] f, input logic [31:0] w,
                                input logic [31:0] h, input logic [31:0] t);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_reg(CSR_FOCAL, f);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_THRESH, t);
      @(negedge clock);
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_FOCAL;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = KIND_LOAD;
      rsp_tready  = 1'b1;
      stall_cycle = 0;
      burst_left  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset camera settings
      load_pixel(20'd0, 32'h7FFFFFFF, 1'b1);
      load_pixel(20'hFFFFF, 32'h80000000, 1'b0);
      load_pixel(20'hFFFFF, 32'h00010000, 1'b1);
      test_point(32'd0, 32'd0, 32'd0);
      test_point(32'd0, 32'd0, 32'h80000000);
      test_point(32'd0, 32'd0, 32'hFFFFFFFF);
      test_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      test_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
      test_point(32'h80000000, 32'h7FFFFFFF, 32'h00000001);
      test_point(32'd0, 32'd0, 32'h00010000);
      test_point(32'd0, 32'd0, 32'h00010000);
      test_point(32'hFFFF0000, 32'h0000FFFF, 32'h00020000);
      test_point(32'h0, 32'h0, 32'h7FFFFFFF);
      repeat (ITEMS_PER_SETTING) random_item();

      apply_setting(32'd34406400, 32'd1024, 32'd1024, 32'd0);
      test_point(32'd0, 32'd0, 32'h00010000);
      repeat (ITEMS_PER_SETTING) random_item();

      apply_setting(32'd1, 32'd1, 32'd1, 32'hFFFFFF);
      test_point(32'h7FFFFFFF, 32'h80000000, 32'h00000001);
      repeat (ITEMS_PER_SETTING) random_item();

      // oversized registers clamp to the image store
      apply_setting(32'hFFFFFFFF, 32'd2047, 32'd16, $urandom_range(0, 32'hFFFFFF));
      repeat (ITEMS_PER_SETTING) random_item();

      // zero focal length lands on the principal point
      apply_setting(32'd0, 32'd33, 32'd1500, $urandom_range(0, 4096));
      repeat (ITEMS_PER_SETTING / 2) random_item();

      // zero width: every test is outside view
      apply_setting(32'd65536, 32'd0, 32'd5, 32'd655);
      repeat (ITEMS_PER_SETTING / 4) random_item();

      apply_setting($urandom_range(32'h00010000, 32'h04000000), $urandom_range(1, 1024),
                    $urandom_range(1, 1024), $urandom_range(0, 32'h00100000));
      repeat (ITEMS_PER_SETTING) random_item();

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
